### sv/railcom_ch1_address_qualifier_top_assert.svh
// Assertion macros used by the address qualifier checker.
`ifndef RAILCOM_CH1_ADDRESS_QUALIFIER_TOP_ASSERT_SVH
`define RAILCOM_CH1_ADDRESS_QUALIFIER_TOP_ASSERT_SVH

// Consequent is checked at the same edge as the antecedent.
`define RACQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: assertion failed");

// Consequent is checked at the next edge after the antecedent.
`define RACQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: assertion failed");

`endif

### sv/racq_pkg.sv
// Types, constants and helper functions of the address qualifier.
package racq_pkg;

    localparam int TRACK_COUNT_DEFAULT = 8;
    // The 3-bit track index reaches at most this many tracks.
    localparam int TRACK_REACH = 8;

    typedef logic [1:0] cfg_index_t;

    localparam cfg_index_t REG_REPEAT_THRESHOLD = 2'd0;
    localparam cfg_index_t REG_SYMBOL_MAX       = 2'd1;
    localparam cfg_index_t REG_FIRST_PART_ID    = 2'd2;
    localparam cfg_index_t REG_SECOND_PART_ID   = 2'd3;

    typedef struct packed {
        logic [3:0] repeat_threshold;
        logic [7:0] symbol_max;
        logic [3:0] first_part_id;
        logic [3:0] second_part_id;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        repeat_threshold: 4'd3,
        symbol_max:       8'd63,
        first_part_id:    4'd1,
        second_part_id:   4'd2
    };

    typedef struct packed {
        logic        report;
        logic [2:0]  track;
        logic [13:0] address;
    } result_t;

    localparam logic [3:0] FRAME_SYMBOLS = 4'd2;
    localparam logic [7:0] LONG_MASK     = 8'h3F;

    // A repeated payload counts up to the threshold and holds; a new one restarts at 1.
    function automatic logic [3:0] next_count(
        input logic [7:0] part,
        input logic [3:0] cnt,
        input logic [7:0] payload,
        input logic [3:0] threshold
    );
        logic [3:0] result;
        if (part == payload) begin
            if (cnt < threshold)
                result = cnt + 4'd1;
            else
                result = cnt;
        end
        else begin
            result = 4'd1;
        end
        return result;
    endfunction

    // Bit 7 of the upper part marks a long address.
    function automatic logic [13:0] join_address(
        input logic [7:0] hi,
        input logic [7:0] lo
    );
        logic [7:0] hi_bits;
        hi_bits = hi & LONG_MASK;
        if (hi[7])
            return {hi_bits[5:0], lo};
        else
            return {6'd0, lo};
    endfunction

endpackage

### sv/racq_cfg.sv
// Configuration register file of the address qualifier.
module racq_cfg (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    input  racq_pkg::cfg_index_t  cfg_index,
    input  logic [7:0]            cfg_data,
    output racq_pkg::cfg_t        cfg
);
    import racq_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_REPEAT_THRESHOLD: cfg_next.repeat_threshold = cfg_data[3:0];
                REG_SYMBOL_MAX:       cfg_next.symbol_max       = cfg_data;
                REG_FIRST_PART_ID:    cfg_next.first_part_id    = cfg_data[3:0];
                REG_SECOND_PART_ID:   cfg_next.second_part_id   = cfg_data[3:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= CFG_RESET;
        else
            cfg_reg <= cfg_next;
    end

    assign cfg = cfg_reg;

endmodule

### sv/racq_core.sv
// Per-track address state with its read-modify-write update and result check.
module racq_core #(
    parameter int TRACK_COUNT = racq_pkg::TRACK_COUNT_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  logic [2:0]        track,
    input  logic [3:0]        symbol_count,
    input  logic [7:0]        first_symbol,
    input  logic [7:0]        second_symbol,
    input  racq_pkg::cfg_t    cfg,
    output racq_pkg::result_t result
);
    import racq_pkg::*;

    localparam int DEPTH = (TRACK_COUNT < TRACK_REACH) ? TRACK_COUNT : TRACK_REACH;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [6:0] TRACK_LIMIT = 7'(TRACK_COUNT);

    logic [7:0] upper_part_reg  [DEPTH];
    logic [7:0] lower_part_reg  [DEPTH];
    logic [3:0] upper_count_reg [DEPTH];
    logic [3:0] lower_count_reg [DEPTH];

    logic [IDX_W-1:0] idx;
    logic             in_range;
    logic             parsed;
    logic [3:0]       msg_id;
    logic [7:0]       payload;
    logic             hit_upper;
    logic             hit_lower;
    logic [7:0]       upper_part_next;
    logic [7:0]       lower_part_next;
    logic [3:0]       upper_count_next;
    logic [3:0]       lower_count_next;

    assign idx      = track[IDX_W-1:0];
    assign in_range = {4'd0, track} < TRACK_LIMIT;

    assign parsed = (symbol_count == FRAME_SYMBOLS)
                 && (first_symbol <= cfg.symbol_max)
                 && (second_symbol <= cfg.symbol_max);
    assign msg_id  = first_symbol[5:2];
    assign payload = {first_symbol[1:0], 6'd0} | second_symbol;

    // With equal ids the upper part takes precedence.
    assign hit_upper = parsed && (msg_id == cfg.first_part_id);
    assign hit_lower = parsed && !hit_upper && (msg_id == cfg.second_part_id);

    always_comb
    begin
        upper_part_next  = upper_part_reg[idx];
        lower_part_next  = lower_part_reg[idx];
        upper_count_next = upper_count_reg[idx];
        lower_count_next = lower_count_reg[idx];
        if (hit_upper)
        begin
            upper_count_next = next_count(upper_part_reg[idx], upper_count_reg[idx],
                                          payload, cfg.repeat_threshold);
            upper_part_next  = payload;
        end
        if (hit_lower)
        begin
            lower_count_next = next_count(lower_part_reg[idx], lower_count_reg[idx],
                                          payload, cfg.repeat_threshold);
            lower_part_next  = payload;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int t = 0; t < DEPTH; t++)
            begin
                upper_part_reg[t]  <= 8'd0;
                lower_part_reg[t]  <= 8'd0;
                upper_count_reg[t] <= 4'd0;
                lower_count_reg[t] <= 4'd0;
            end
        end
        else if (fire && in_range)
        begin
            upper_part_reg[idx]  <= upper_part_next;
            lower_part_reg[idx]  <= lower_part_next;
            upper_count_reg[idx] <= upper_count_next;
            lower_count_reg[idx] <= lower_count_next;
        end
    end

    assign result.report  = in_range
                         && (upper_count_next == cfg.repeat_threshold)
                         && (lower_count_next == cfg.repeat_threshold);
    assign result.track   = track;
    assign result.address = join_address(upper_part_next, lower_part_next);

endmodule

### sv/railcom_ch1_address_qualifier_top.sv
// Top level of the RailCom channel-1 address qualifier.
// The block takes one channel-1 frame word per clock cycle while in_stall is low and gives its
// result, if any, from the result register: the word is first held in the input register, then
// the per-track state is read, updated and written back in the same cycle as the result register
// loads. As that read-modify-write of the per-track counters completes in the update stage, the
// rate is one word per cycle unless the output stalls, so frames for the same track may follow
// each other directly. A word gives a result only when both address parts of its track have
// been seen repeat_threshold times in a row; other words are absorbed without output. A held
// result stalls the input only when the next word reaches the update stage. Configuration writes
// are always taken (cfg_ready is tied high) and must be issued only while no word is in flight.
module railcom_ch1_address_qualifier_top #(
    parameter int TRACK_COUNT = racq_pkg::TRACK_COUNT_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [2:0]            track_index,
    input  logic [3:0]            symbol_count,
    input  logic [7:0]            first_symbol,
    input  logic [7:0]            second_symbol,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [2:0]            out_track,
    output logic [13:0]           loco_address,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  racq_pkg::cfg_index_t  cfg_index,
    input  logic [7:0]            cfg_data
);
    import racq_pkg::*;

    cfg_t        cfg;
    result_t     result;

    logic        in_valid_reg;
    logic [2:0]  track_reg;
    logic [3:0]  symbol_count_reg;
    logic [7:0]  first_symbol_reg;
    logic [7:0]  second_symbol_reg;
    logic        out_valid_reg;
    logic [2:0]  out_track_reg;
    logic [13:0] loco_address_reg;

    logic        accept;
    logic        out_free;
    logic        fire;

    assign cfg_ready = 1'b1;

    racq_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    racq_core #(
        .TRACK_COUNT (TRACK_COUNT)
    ) u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .fire          (fire),
        .track         (track_reg),
        .symbol_count  (symbol_count_reg),
        .first_symbol  (first_symbol_reg),
        .second_symbol (second_symbol_reg),
        .cfg           (cfg),
        .result        (result)
    );

    // The update stage moves whenever the result register can take a new word.
    assign out_free = !out_valid_reg || !out_stall;
    assign fire     = in_valid_reg && out_free;
    assign in_stall = in_valid_reg && !out_free;
    assign accept   = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (accept)
            in_valid_reg <= 1'b1;
        else if (fire)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            track_reg         <= track_index;
            symbol_count_reg  <= symbol_count;
            first_symbol_reg  <= first_symbol;
            second_symbol_reg <= second_symbol;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= fire && result.report;
    end

    always_ff @(posedge clk)
    begin
        if (fire && result.report)
        begin
            out_track_reg    <= result.track;
            loco_address_reg <= result.address;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_track    = out_track_reg;
    assign loco_address = loco_address_reg;

endmodule

### sv/racq_checker.sv
// Port-level checker of the address qualifier and its bind.
`include "railcom_ch1_address_qualifier_top_assert.svh"

module racq_checker #(
    parameter int TRACK_COUNT = racq_pkg::TRACK_COUNT_DEFAULT
) (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [2:0]  out_track,
    input logic [13:0] loco_address
);
    // A held result word keeps its contents.
    `RACQ_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_track) && $stable(loco_address))

    // A fresh result follows an accepted word through the input register and the result register.
    `RACQ_ASSERT_NOW(a_out_latency, clk, rst_n, $rose(out_valid), $past(in_valid && !in_stall, 2))

    // Tracks beyond the configured count never report.
    `RACQ_ASSERT_NOW(a_track_range, clk, rst_n, out_valid, int'(out_track) < TRACK_COUNT)

endmodule

bind railcom_ch1_address_qualifier_top racq_checker #(
    .TRACK_COUNT (TRACK_COUNT)
) u_racq_checker (.*);
